// ----- hdl/ssir_pkg.sv -----
// Shared types and codes for the sorted set insert and remove block.
package ssir_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 7;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    MODE_SEARCH = 4'b0001,
    MODE_CARRY  = 4'b0010,
    MODE_SHIFT  = 4'b0100,
    MODE_DONE   = 4'b1000
  } mode_e;

  typedef struct packed {
    logic              active;
    func_e             func;
    logic              full;
    mode_e             mode;
    status_e           status;
    logic [ValueW-1:0] value;
  } token_t;

endpackage

// ----- hdl/ssir_cell.sv -----
// One storage cell of the sorted chain: holds one entry and steps the operation token onward.
module ssir_cell #(
  parameter int unsigned CNT_W = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssir_pkg::token_t            tok_i,
  input  logic [CNT_W-1:0]            rem_i,
  input  logic [ssir_pkg::ValueW-1:0] next_entry_i,
  output ssir_pkg::token_t            tok_o,
  output logic [CNT_W-1:0]            rem_o,
  output logic [ssir_pkg::ValueW-1:0] entry_o
);
  import ssir_pkg::*;

  logic [ValueW-1:0] entry_q, entry_d;
  token_t            tok_q, tok_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              valid, eq, lt;

  assign valid = (rem_i != '0);
  assign eq    = valid && (entry_q == tok_i.value);
  assign lt    = valid && ($signed(entry_q) < $signed(tok_i.value));

  always_comb begin
    tok_d   = tok_i;
    entry_d = entry_q;
    rem_d   = valid ? rem_i - CNT_W'(1) : rem_i;
    if (tok_i.active) begin
      unique case (tok_i.mode)
        MODE_SEARCH: begin
          if (tok_i.func == FUNC_INSERT) begin
            priority if (eq) begin
              tok_d.status = ST_DUPLICATE;
              tok_d.mode   = MODE_DONE;
            end else if (lt) begin
              tok_d.mode = MODE_SEARCH;
            end else if (tok_i.full) begin
              tok_d.status = ST_FULL;
              tok_d.mode   = MODE_DONE;
            end else begin
              entry_d      = tok_i.value;
              tok_d.value  = entry_q;
              tok_d.status = ST_INSERTED;
              tok_d.mode   = valid ? MODE_CARRY : MODE_DONE;
            end
          end else begin
            priority if (eq) begin
              entry_d      = next_entry_i;
              tok_d.status = ST_REMOVED;
              tok_d.mode   = MODE_SHIFT;
            end else if (lt) begin
              tok_d.mode = MODE_SEARCH;
            end else begin
              tok_d.status = ST_NOT_FOUND;
              tok_d.mode   = MODE_DONE;
            end
          end
        end
        MODE_CARRY: begin
          entry_d     = tok_i.value;
          tok_d.value = entry_q;
          if (!valid) begin
            tok_d.mode = MODE_DONE;
          end
        end
        MODE_SHIFT: begin
          entry_d = next_entry_i;
        end
        MODE_DONE: begin
          entry_d = entry_q;
        end
        default: begin
          entry_d = entry_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rem_q   <= rem_d;
  end

  assign tok_o   = tok_q;
  assign rem_o   = rem_q;
  assign entry_o = entry_q;

endmodule

// ----- hdl/sorted_set_insert_remove.sv -----
// Top level of the sorted set: a chain of cells that keeps distinct signed values in order.
//
// Input channel s_axis: tuser[0] selects the operation (0 insert, 1 remove) and
// tdata[31:0] carries the signed value. Output channel m_axis returns one item
// per input item: tdata[2:0] is the status and tdata[9:3] the number of stored
// values after the operation.
// An accepted item travels through the chain one cell per cycle. One operation
// is in the chain at a time: a new item is not accepted until the last one has
// left the chain. The walk length is set by the number of cells in the chain.
// A finished result waits in the output register and, if that is still full,
// in a second holding register; a new item is accepted while one result waits.
// When both registers are full, s_axis_tready stays low until m_axis drains.
// Reset empties the set and drops any result not yet delivered.
module sorted_set_insert_remove #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[31:0]
  input  logic [0:0]  s_axis_tuser,  // func[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status[2:0], entry_count[9:3], zero[15:10]
);
  import ssir_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  token_t            tok [CAPACITY+1];
  logic [CntW-1:0]   rem [CAPACITY+1];
  logic [ValueW-1:0] entry [CAPACITY];

  logic              busy_q, busy_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic              pend_valid_q, pend_valid_d;
  status_e           pend_status_q, pend_status_d;
  logic [CountW-1:0] pend_count_q, pend_count_d;

  logic              accept, exit_v, out_free;
  status_e           res_status;
  logic [CountW-1:0] res_count;

  assign s_axis_tready = !busy_q && !pend_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    tok[0]        = '0;
    tok[0].active = accept;
    tok[0].func   = func_e'(s_axis_tuser[0]);
    tok[0].full   = (count_q == CntW'(CAPACITY));
    tok[0].mode   = MODE_SEARCH;
    tok[0].status = ST_NOT_FOUND;
    tok[0].value  = s_axis_tdata;
  end
  assign rem[0] = count_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ValueW-1:0] next_entry;
    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end
    ssir_cell #(
      .CNT_W(CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok[i]),
      .rem_i       (rem[i]),
      .next_entry_i(next_entry),
      .tok_o       (tok[i+1]),
      .rem_o       (rem[i+1]),
      .entry_o     (entry[i])
    );
  end

  assign exit_v   = tok[CAPACITY].active;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    count_d    = count_q;
    res_status = tok[CAPACITY].status;
    if (tok[CAPACITY].mode == MODE_SEARCH) begin
      res_status = (tok[CAPACITY].func == FUNC_INSERT) ? ST_FULL : ST_NOT_FOUND;
    end
    if (exit_v && res_status == ST_INSERTED) begin
      count_d = count_q + CntW'(1);
    end else if (exit_v && res_status == ST_REMOVED) begin
      count_d = count_q - CntW'(1);
    end
    res_count = CountW'(count_d);
  end

  always_comb begin
    busy_d        = busy_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_count_d   = out_count_q;
    pend_valid_d  = pend_valid_q;
    pend_status_d = pend_status_q;
    pend_count_d  = pend_count_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (exit_v) begin
      busy_d = 1'b0;
    end
    priority if (exit_v && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status;
      out_count_d  = res_count;
    end else if (exit_v) begin
      pend_valid_d  = 1'b1;
      pend_status_d = res_status;
      pend_count_d  = res_count;
    end else if (pend_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = pend_status_q;
      out_count_d  = pend_count_q;
      pend_valid_d = 1'b0;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q  <= out_status_d;
    out_count_q   <= out_count_d;
    pend_status_q <= pend_status_d;
    pend_count_q  <= pend_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_count_q, out_status_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_q)
    else $error("Accepted item did not start a walk through the chain.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) exit_v |-> busy_q)
    else $error("Item left the chain while no operation was in progress.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(CAPACITY))
    else $error("Stored count exceeds the capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_valid_q |-> out_valid_q)
    else $error("Held result present while the output register is empty.");

endmodule
